// ===== sv/dpbu_pkg.sv =====
// Shared types, constants and fixed-point helpers for the depth back-projection block.
`timescale 1ns / 1ps
package dpbu_pkg;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] Q_ONE   = 32'sh0100_0000;
	// quotient bits of the reciprocal: 2^48 / d needs 49 of them
	localparam int DIV_W = 49;

	typedef enum logic [2:0] {
		CFG_INV_FOCAL       = 3'd0,
		CFG_PRINCIPAL_POINT = 3'd1,
		CFG_RADIAL_K1       = 3'd2,
		CFG_RADIAL_K2       = 3'd3,
		CFG_RADIAL_K3       = 3'd4,
		CFG_TANGENTIAL_P1   = 3'd5,
		CFG_TANGENTIAL_P2   = 3'd6,
		CFG_UNDISTORT_EN    = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [11:0] pixel_col;
		logic [11:0] pixel_row;
		logic [15:0] depth_mm;
	} pix_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic [15:0]        point_z;
		logic               saturated;
	} point_t;

	typedef struct packed {
		logic signed [31:0] k1;
		logic signed [31:0] k2;
		logic signed [31:0] k3;
		logic signed [31:0] p1;
		logic signed [31:0] p2;
	} coef_t;

	// per-pixel values that ride along the whole pipeline
	typedef struct packed {
		logic signed [31:0] x0;
		logic signed [31:0] y0;
		logic [15:0]        z;
		logic               nflag;
		logic               iflag;
	} item_t;

	// sideband carried through the reciprocal cells
	typedef struct packed {
		item_t              it;
		logic signed [31:0] ex;
		logic signed [31:0] ey;
		logic               neg;
		logic               dz;
	} dside_t;

	typedef struct packed {
		logic               f;
		logic signed [31:0] v;
	} qv_t;

	function automatic qv_t qsat(input logic signed [63:0] v);
		qv_t r;
		r.f = 1'b0;
		r.v = v[31:0];
		if (v > 64'(S32_MAX)) begin
			r.f = 1'b1;
			r.v = S32_MAX;
		end else if (v < 64'(S32_MIN)) begin
			r.f = 1'b1;
			r.v = S32_MIN;
		end
		return r;
	endfunction

	// Q8.24 product: round half up, floor shift, saturate
	function automatic qv_t qrnd(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = (p + 64'sd8388608) >>> 24;
		return qsat(t);
	endfunction

	function automatic qv_t qadd(input logic signed [31:0] a, input logic signed [31:0] b);
		return qsat(64'(a) + 64'(b));
	endfunction

	function automatic qv_t qsub(input logic signed [31:0] a, input logic signed [31:0] b);
		return qsat(64'(a) - 64'(b));
	endfunction

endpackage

// ===== sv/dpbu_norm.sv =====
// Pixel normalization by principal point and inverse focal length.
`timescale 1ns / 1ps
module dpbu_norm (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vin,
	input  dpbu_pkg::pix_t        pix,
	input  logic [63:0]           inv_focal,
	input  logic [63:0]           principal_point,
	output logic                  vout,
	output dpbu_pkg::item_t       it_out
);

	logic [31:0] posx, posy, magx, magy;
	logic        negx, negy;

	logic        v_s1, v_s2;
	logic [31:0] magx_s1, magy_s1;
	logic        negx_s1, negy_s1, negx_s2, negy_s2;
	logic [15:0] z_s1, z_s2;
	logic [63:0] px_s2, py_s2;

	logic [64:0]        sx, sy;
	logic signed [63:0] rx, ry;
	dpbu_pkg::qv_t      qx, qy;

	always_comb begin
		posx = {4'd0, pix.pixel_col, 16'd0};
		posy = {4'd0, pix.pixel_row, 16'd0};
		negx = posx < principal_point[31:0];
		negy = posy < principal_point[63:32];
		magx = negx ? principal_point[31:0] - posx : posx - principal_point[31:0];
		magy = negy ? principal_point[63:32] - posy : posy - principal_point[63:32];
		sx = {1'b0, px_s2} + 65'd8388608;
		sy = {1'b0, py_s2} + 65'd8388608;
		rx = $signed({23'd0, sx[64:24]});
		ry = $signed({23'd0, sy[64:24]});
		if (negx_s2) rx = -rx;
		if (negy_s2) ry = -ry;
		qx = dpbu_pkg::qsat(rx);
		qy = dpbu_pkg::qsat(ry);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			vout <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
			vout <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			magx_s1 <= magx;
			magy_s1 <= magy;
			negx_s1 <= negx;
			negy_s1 <= negy;
			z_s1    <= pix.depth_mm;
			px_s2   <= 64'(magx_s1) * 64'(inv_focal[31:0]);
			py_s2   <= 64'(magy_s1) * 64'(inv_focal[63:32]);
			negx_s2 <= negx_s1;
			negy_s2 <= negy_s1;
			z_s2    <= z_s1;
			it_out.x0    <= qx.v;
			it_out.y0    <= qy.v;
			it_out.z     <= z_s2;
			it_out.nflag <= qx.f | qy.f;
			it_out.iflag <= 1'b0;
		end
	end

endmodule

// ===== sv/dpbu_div_cell.sv =====
// One restoring-division cell: settles one quotient bit and hands on the remainder.
`timescale 1ns / 1ps
module dpbu_div_cell #(
	parameter int BIT = 0,
	parameter int SW  = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vin,
	input  logic [31:0]                 rem_in,
	input  logic [dpbu_pkg::DIV_W-1:0]  num_in,
	input  logic [dpbu_pkg::DIV_W-1:0]  q_in,
	input  logic [31:0]                 mag_in,
	input  logic [SW-1:0]               sb_in,
	output logic                        vout,
	output logic [31:0]                 rem_out,
	output logic [dpbu_pkg::DIV_W-1:0]  num_out,
	output logic [dpbu_pkg::DIV_W-1:0]  q_out,
	output logic [31:0]                 mag_out,
	output logic [SW-1:0]               sb_out
);

	logic [32:0]                rp, rn;
	logic                       ge;
	logic [dpbu_pkg::DIV_W-1:0] qn;

	always_comb begin
		rp = {rem_in, num_in[BIT]};
		ge = rp >= {1'b0, mag_in};
		rn = ge ? rp - {1'b0, mag_in} : rp;
		qn = q_in;
		qn[BIT] = ge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= rn[31:0];
			num_out <= num_in;
			q_out   <= qn;
			mag_out <= mag_in;
			sb_out  <= sb_in;
		end
	end

endmodule

// ===== sv/dpbu_iter.sv =====
// One undistortion iteration: distortion terms, reciprocal cell chain, correction.
`timescale 1ns / 1ps
module dpbu_iter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vin,
	input  dpbu_pkg::item_t     it_in,
	input  logic signed [31:0]  x_in,
	input  logic signed [31:0]  y_in,
	input  dpbu_pkg::coef_t     coef,
	output logic                vout,
	output dpbu_pkg::item_t     it_out,
	output logic signed [31:0]  x_out,
	output logic signed [31:0]  y_out
);

	localparam int DW = dpbu_pkg::DIV_W;
	localparam int SB = $bits(dpbu_pkg::dside_t);

	logic [8:1] v_q;
	logic       v_s9, v_s10;

	dpbu_pkg::item_t it_s1, it_s2, it_s3, it_s4, it_s5, it_s6, it_s7, it_s8;
	dpbu_pkg::item_t it_s9, it_s10;

	// next values of the item with the stage's clip flags merged in
	dpbu_pkg::item_t nit2, nit3, nit4, nit5, nit6, nit9, nit_out;

	logic signed [63:0] xx_s1, yy_s1, xy_s1;
	logic signed [31:0] r2_s2, xx2_s2, yy2_s2, xy2_s2;
	logic signed [63:0] k3r2_s3, p1xy_s3, p2xy_s3;
	logic signed [31:0] tx_s3, ty_s3, r2_s3;
	logic signed [31:0] poly_s4, a_s4, b_s4, r2_s4;
	logic signed [63:0] p2tx_s4, p1ty_s4;
	logic signed [63:0] pr_s5;
	logic signed [31:0] dx_s5, dy_s5, r2_s5;
	logic signed [31:0] poly_s6, ex_s6, ey_s6, r2_s6;
	logic signed [63:0] pr_s7;
	logic signed [31:0] ex_s7, ey_s7;
	logic signed [31:0] d_s8, ex_s8, ey_s8;
	logic               f8_s8;
	logic signed [31:0] icd_s9, ex_s9, ey_s9;
	logic signed [63:0] mx_s10, my_s10;

	dpbu_pkg::qv_t fxx, fyy, fxy, fr2, fxx2, fyy2, fxy2;
	dpbu_pkg::qv_t ftx, fty;
	dpbu_pkg::qv_t fk3, fpoly, fa, fb;
	dpbu_pkg::qv_t fp2tx, fp1ty, fdx, fdy;
	dpbu_pkg::qv_t fpr, fpoly2, fex, fey;
	dpbu_pkg::qv_t fpr2, fd;
	dpbu_pkg::qv_t ficd, fmx, fmy;

	logic [31:0]          dmag;
	logic [DW-1:0]        dnum;
	logic signed [63:0]   qx;
	dpbu_pkg::dside_t     dsb_in, dsb_out;

	logic                 dv   [0:DW];
	logic [31:0]          drem [0:DW];
	logic [DW-1:0]        dn   [0:DW];
	logic [DW-1:0]        dq   [0:DW];
	logic [31:0]          dm   [0:DW];
	logic [SB-1:0]        dsb  [0:DW];

	always_comb begin
		fxx  = dpbu_pkg::qrnd(xx_s1);
		fyy  = dpbu_pkg::qrnd(yy_s1);
		fxy  = dpbu_pkg::qrnd(xy_s1);
		fr2  = dpbu_pkg::qadd(fxx.v, fyy.v);
		fxx2 = dpbu_pkg::qadd(fxx.v, fxx.v);
		fyy2 = dpbu_pkg::qadd(fyy.v, fyy.v);
		fxy2 = dpbu_pkg::qadd(fxy.v, fxy.v);
		nit2       = it_s1;
		nit2.iflag = it_s1.iflag | fxx.f | fyy.f | fxy.f | fr2.f | fxx2.f | fyy2.f
			| fxy2.f;

		ftx  = dpbu_pkg::qadd(r2_s2, xx2_s2);
		fty  = dpbu_pkg::qadd(r2_s2, yy2_s2);
		nit3       = it_s2;
		nit3.iflag = it_s2.iflag | ftx.f | fty.f;

		fk3   = dpbu_pkg::qrnd(k3r2_s3);
		fpoly = dpbu_pkg::qadd(fk3.v, coef.k2);
		fa    = dpbu_pkg::qrnd(p1xy_s3);
		fb    = dpbu_pkg::qrnd(p2xy_s3);
		nit4       = it_s3;
		nit4.iflag = it_s3.iflag | fk3.f | fpoly.f | fa.f | fb.f;

		fp2tx = dpbu_pkg::qrnd(p2tx_s4);
		fp1ty = dpbu_pkg::qrnd(p1ty_s4);
		fdx   = dpbu_pkg::qadd(a_s4, fp2tx.v);
		fdy   = dpbu_pkg::qadd(fp1ty.v, b_s4);
		nit5       = it_s4;
		nit5.iflag = it_s4.iflag | fp2tx.f | fp1ty.f | fdx.f | fdy.f;

		fpr    = dpbu_pkg::qrnd(pr_s5);
		fpoly2 = dpbu_pkg::qadd(fpr.v, coef.k1);
		fex    = dpbu_pkg::qsub(it_s5.x0, dx_s5);
		fey    = dpbu_pkg::qsub(it_s5.y0, dy_s5);
		nit6       = it_s5;
		nit6.iflag = it_s5.iflag | fpr.f | fpoly2.f | fex.f | fey.f;

		fpr2 = dpbu_pkg::qrnd(pr_s7);
		fd   = dpbu_pkg::qadd(fpr2.v, dpbu_pkg::Q_ONE);

		// reciprocal operands: 2^48 + |d|/2 over |d|
		dmag = d_s8[31] ? 32'(-64'(d_s8)) : d_s8;
		dnum = {1'b1, 48'd0} + DW'(dmag >> 1);
		dsb_in.it  = it_s8;
		dsb_in.it.iflag = it_s8.iflag | f8_s8;
		dsb_in.ex  = ex_s8;
		dsb_in.ey  = ey_s8;
		dsb_in.neg = d_s8[31];
		dsb_in.dz  = d_s8 == 32'sd0;

		dsb_out = dsb[DW];
		qx = $signed({{(64 - DW){1'b0}}, dq[DW]});
		if (dsb_out.neg) qx = -qx;
		ficd = dpbu_pkg::qsat(qx);
		if (dsb_out.dz) begin
			ficd.f = 1'b1;
			ficd.v = dpbu_pkg::S32_MAX;
		end
		nit9       = dsb_out.it;
		nit9.iflag = dsb_out.it.iflag | ficd.f;

		fmx = dpbu_pkg::qrnd(mx_s10);
		fmy = dpbu_pkg::qrnd(my_s10);
		nit_out       = it_s10;
		nit_out.iflag = it_s10.iflag | fmx.f | fmy.f;
	end

	assign dv[0]   = v_q[8];
	assign drem[0] = 32'd0;
	assign dn[0]   = dnum;
	assign dq[0]   = '0;
	assign dm[0]   = dmag;
	assign dsb[0]  = dsb_in;

	for (genvar g = 0; g < DW; g++) begin : g_div
		dpbu_div_cell #(
			.BIT(DW - 1 - g),
			.SW (SB)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vin    (dv[g]),
			.rem_in (drem[g]),
			.num_in (dn[g]),
			.q_in   (dq[g]),
			.mag_in (dm[g]),
			.sb_in  (dsb[g]),
			.vout   (dv[g+1]),
			.rem_out(drem[g+1]),
			.num_out(dn[g+1]),
			.q_out  (dq[g+1]),
			.mag_out(dm[g+1]),
			.sb_out (dsb[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= '0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			vout  <= 1'b0;
		end else if (en) begin
			v_q   <= {v_q[7:1], vin};
			v_s9  <= dv[DW];
			v_s10 <= v_s9;
			vout  <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= it_in;
			xx_s1 <= 64'(x_in) * 64'(x_in);
			yy_s1 <= 64'(y_in) * 64'(y_in);
			xy_s1 <= 64'(x_in) * 64'(y_in);

			it_s2  <= nit2;
			r2_s2  <= fr2.v;
			xx2_s2 <= fxx2.v;
			yy2_s2 <= fyy2.v;
			xy2_s2 <= fxy2.v;

			it_s3   <= nit3;
			k3r2_s3 <= 64'(coef.k3) * 64'(r2_s2);
			p1xy_s3 <= 64'(coef.p1) * 64'(xy2_s2);
			p2xy_s3 <= 64'(coef.p2) * 64'(xy2_s2);
			tx_s3   <= ftx.v;
			ty_s3   <= fty.v;
			r2_s3   <= r2_s2;

			it_s4   <= nit4;
			poly_s4 <= fpoly.v;
			a_s4    <= fa.v;
			b_s4    <= fb.v;
			p2tx_s4 <= 64'(coef.p2) * 64'(tx_s3);
			p1ty_s4 <= 64'(coef.p1) * 64'(ty_s3);
			r2_s4   <= r2_s3;

			it_s5 <= nit5;
			pr_s5 <= 64'(poly_s4) * 64'(r2_s4);
			dx_s5 <= fdx.v;
			dy_s5 <= fdy.v;
			r2_s5 <= r2_s4;

			it_s6   <= nit6;
			poly_s6 <= fpoly2.v;
			ex_s6   <= fex.v;
			ey_s6   <= fey.v;
			r2_s6   <= r2_s5;

			it_s7 <= it_s6;
			pr_s7 <= 64'(poly_s6) * 64'(r2_s6);
			ex_s7 <= ex_s6;
			ey_s7 <= ey_s6;

			it_s8 <= it_s7;
			d_s8  <= fd.v;
			f8_s8 <= fpr2.f | fd.f;
			ex_s8 <= ex_s7;
			ey_s8 <= ey_s7;

			it_s9  <= nit9;
			icd_s9 <= ficd.v;
			ex_s9  <= dsb_out.ex;
			ey_s9  <= dsb_out.ey;

			it_s10 <= it_s9;
			mx_s10 <= 64'(ex_s9) * 64'(icd_s9);
			my_s10 <= 64'(ey_s9) * 64'(icd_s9);

			it_out <= nit_out;
			x_out  <= fmx.v;
			y_out  <= fmy.v;
		end
	end

endmodule

// ===== sv/depth_pixel_backproject_undistort.sv =====
// Top level: depth pixel to 3D point with iterative lens undistortion.
`timescale 1ns / 1ps
// Usage
//   Pixels enter on pix_valid / pix_ready / pix_data (column, row, depth in mm);
//   one transfer moves one pixel. Points leave on pt_valid / pt_ready / pt_data
//   as signed Q24.8 x and y, z equal to the depth, and a saturation flag.
//   Configuration goes in through cfg_we / cfg_index / cfg_data, one register
//   per write; the user must write only while no pixel is in flight, as the
//   block does not enforce it. Throughput: one pixel per clock while the skid
//   register is empty. Every stage is a register, so a new pixel enters while
//   earlier ones are still in the cell chain.
//   Pipeline: three normalization stages, per iteration eight distortion
//   stages, 49 reciprocal cells (one quotient bit each) and three correction
//   stages, then two output stages. The pipeline runs the iterations always;
//   with undistortion off the normalized point is taken at the end instead.
//   Reset clears all valid bits, the skid register and the configuration
//   registers; data stages are not reset and fill as pixels advance.
//   Stall: a one-entry skid register catches the point that the receiver does
//   not take; while it is full the whole pipeline holds and pix_ready is low.
module depth_pixel_backproject_undistort #(
	parameter int UNDISTORT_ITERATIONS = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	output logic                pix_ready,
	input  dpbu_pkg::pix_t      pix_data,
	output logic                pt_valid,
	input  logic                pt_ready,
	output dpbu_pkg::point_t    pt_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data
);

	localparam int N = UNDISTORT_ITERATIONS;

	// configuration registers
	logic [63:0]     inv_focal_q, principal_point_q;
	dpbu_pkg::coef_t coef_q;
	logic            undist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_focal_q       <= '0;
			principal_point_q <= '0;
			coef_q            <= '0;
			undist_q          <= 1'b0;
		end else if (cfg_we) begin
			case (dpbu_pkg::cfg_idx_t'(cfg_index))
				dpbu_pkg::CFG_INV_FOCAL:       inv_focal_q       <= cfg_data;
				dpbu_pkg::CFG_PRINCIPAL_POINT: principal_point_q <= cfg_data;
				dpbu_pkg::CFG_RADIAL_K1:       coef_q.k1         <= cfg_data[31:0];
				dpbu_pkg::CFG_RADIAL_K2:       coef_q.k2         <= cfg_data[31:0];
				dpbu_pkg::CFG_RADIAL_K3:       coef_q.k3         <= cfg_data[31:0];
				dpbu_pkg::CFG_TANGENTIAL_P1:   coef_q.p1         <= cfg_data[31:0];
				dpbu_pkg::CFG_TANGENTIAL_P2:   coef_q.p2         <= cfg_data[31:0];
				dpbu_pkg::CFG_UNDISTORT_EN:    undist_q          <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// global advance: hold every stage while the skid register is full
	logic en;
	logic sk_v_q;
	dpbu_pkg::point_t sk_q;

	assign en        = !sk_v_q;
	assign pix_ready = en;

	// normalization, then the chain of iteration cells
	logic               cv  [0:N];
	dpbu_pkg::item_t    cit [0:N];
	logic signed [31:0] cx  [0:N];
	logic signed [31:0] cy  [0:N];

	dpbu_norm u_norm (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.vin            (pix_valid),
		.pix            (pix_data),
		.inv_focal      (inv_focal_q),
		.principal_point(principal_point_q),
		.vout           (cv[0]),
		.it_out         (cit[0])
	);

	assign cx[0] = cit[0].x0;
	assign cy[0] = cit[0].y0;

	for (genvar g = 0; g < N; g++) begin : g_iter
		dpbu_iter u_iter (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.vin   (cv[g]),
			.it_in (cit[g]),
			.x_in  (cx[g]),
			.y_in  (cy[g]),
			.coef  (coef_q),
			.vout  (cv[g+1]),
			.it_out(cit[g+1]),
			.x_out (cx[g+1]),
			.y_out (cy[g+1])
		);
	end

	// output scaling by depth
	logic signed [31:0] sel_x, sel_y;
	logic               sel_f;
	logic               o_v_s1, fin_v_s2;
	logic signed [63:0] px_s1, py_s1;
	logic [15:0]        z_s1;
	logic               f_s1;
	dpbu_pkg::qv_t      fox, foy;
	dpbu_pkg::point_t   fin_s2;

	always_comb begin
		// undistortion off: take the normalized point and its flag only
		sel_x = undist_q ? cx[N] : cit[N].x0;
		sel_y = undist_q ? cy[N] : cit[N].y0;
		sel_f = cit[N].nflag | (undist_q & cit[N].iflag);
		fox = dpbu_pkg::qsat((px_s1 + 64'sd32768) >>> 16);
		foy = dpbu_pkg::qsat((py_s1 + 64'sd32768) >>> 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_s1   <= 1'b0;
			fin_v_s2 <= 1'b0;
		end else if (en) begin
			o_v_s1   <= cv[N];
			fin_v_s2 <= o_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= 64'($signed({1'b0, cit[N].z})) * 64'(sel_x);
			py_s1 <= 64'($signed({1'b0, cit[N].z})) * 64'(sel_y);
			z_s1  <= cit[N].z;
			f_s1  <= sel_f;
			fin_s2.point_x   <= fox.v;
			fin_s2.point_y   <= foy.v;
			fin_s2.point_z   <= z_s1;
			fin_s2.saturated <= f_s1 | fox.f | foy.f;
		end
	end

	// skid register: catch the point that was not taken, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sk_v_q <= 1'b0;
		end else if (sk_v_q) begin
			if (pt_ready) sk_v_q <= 1'b0;
		end else if (fin_v_s2 && !pt_ready) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!sk_v_q && fin_v_s2 && !pt_ready) sk_q <= fin_s2;
	end

	assign pt_valid = sk_v_q | fin_v_s2;
	assign pt_data  = sk_v_q ? sk_q : fin_s2;

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q && !pt_ready |=> sk_v_q && $stable(sk_q))
		else $error("skid register lost a point that was not transferred");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!sk_v_q && fin_v_s2 && !pt_ready |=> sk_v_q)
		else $error("stalled point not caught by the skid register");

	a_pipe_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |=> $stable(fin_v_s2) && $stable(fin_s2))
		else $error("pipeline moved while the skid register was full");

endmodule

// ===== tb/sv/depth_pixel_backproject_undistort_test.sv =====
// Self-checking testbench for the depth pixel back-projection and undistortion block.
`timescale 1ns / 1ps
module depth_pixel_backproject_undistort_test;

	localparam int ITERS     = 5;
	// pipeline depth: normalization, per-iteration and output stages
	localparam int LATENCY   = 3 + 60 * ITERS + 2;
	localparam int WDOG_MAX  = 20000;
	localparam int N_RANDOM  = 1300;

	logic              clk;
	logic              arst_n;
	logic              pix_valid;
	logic              pix_ready;
	dpbu_pkg::pix_t    pix_data;
	logic              pt_valid;
	logic              pt_ready;
	dpbu_pkg::point_t  pt_data;
	logic              cfg_we;
	logic [2:0]        cfg_index;
	logic [63:0]       cfg_data;

	depth_pixel_backproject_undistort #(.UNDISTORT_ITERATIONS(ITERS)) uut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .pix_data(pix_data),
		.pt_valid(pt_valid), .pt_ready(pt_ready), .pt_data(pt_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor's own copy of the configuration
	logic [63:0] m_inv_focal;
	logic [63:0] m_center;
	logic signed [63:0] m_k1, m_k2, m_k3, m_p1, m_p2;
	logic        m_undist;
	bit          clip;

	dpbu_pkg::pix_t   pixel_queue[$];
	dpbu_pkg::point_t point_queue[$];
	int     errors;
	int     wdog;
	bit     hold_sender;
	logic   pix_ready_s;
	logic   pt_seen;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------- fixed-point predictor ----------------
	function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			clip = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			clip = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic logic signed [63:0] mul_q24(input logic signed [63:0] a,
			input logic signed [63:0] b);
		return clamp32((a * b + 64'sd8388608) >>> 24);
	endfunction

	function automatic logic signed [63:0] add_q24(input logic signed [63:0] a,
			input logic signed [63:0] b);
		return clamp32(a + b);
	endfunction

	function automatic logic signed [63:0] recip_q24(input logic signed [63:0] d);
		logic [63:0] mag;
		logic [63:0] q;
		if (d == 0) begin
			clip = 1'b1;
			return 64'sd2147483647;
		end
		mag = (d < 0) ? 64'(-d) : 64'(d);
		q = ((64'd1 << 48) + mag / 2) / mag;
		return clamp32((d < 0) ? -$signed(q) : $signed(q));
	endfunction

	function automatic logic signed [63:0] norm_coord(input logic [11:0] pix,
			input logic [31:0] center, input logic [31:0] inv);
		logic [63:0] pos, mag, r;
		bit neg;
		pos = 64'(pix) << 16;
		if (pos >= 64'(center)) begin
			mag = pos - 64'(center);
			neg = 1'b0;
		end else begin
			mag = 64'(center) - pos;
			neg = 1'b1;
		end
		r = (mag * 64'(inv) + (64'd1 << 23)) >> 24;
		return clamp32(neg ? -$signed(r) : $signed(r));
	endfunction

	function automatic logic signed [63:0] scale_depth(input logic [15:0] z,
			input logic signed [63:0] t);
		return clamp32(($signed({48'd0, z}) * t + 64'sd32768) >>> 16);
	endfunction

	function automatic dpbu_pkg::point_t project_pixel(input dpbu_pkg::pix_t p);
		dpbu_pkg::point_t o;
		logic signed [63:0] x0, y0, x, y, xx, yy, xy, r2, poly, icd, xy2, dx, dy;
		clip = 1'b0;
		x0 = norm_coord(p.pixel_col, m_center[31:0], m_inv_focal[31:0]);
		y0 = norm_coord(p.pixel_row, m_center[63:32], m_inv_focal[63:32]);
		x = x0;
		y = y0;
		if (m_undist) begin
			for (int i = 0; i < ITERS; i++) begin
				xx = mul_q24(x, x);
				yy = mul_q24(y, y);
				xy = mul_q24(x, y);
				r2 = add_q24(xx, yy);
				poly = add_q24(mul_q24(m_k3, r2), m_k2);
				poly = add_q24(mul_q24(poly, r2), m_k1);
				poly = add_q24(mul_q24(poly, r2), 64'sd16777216);
				icd = recip_q24(poly);
				xy2 = add_q24(xy, xy);
				dx = add_q24(mul_q24(m_p1, xy2),
					mul_q24(m_p2, add_q24(r2, add_q24(xx, xx))));
				dy = add_q24(mul_q24(m_p1, add_q24(r2, add_q24(yy, yy))),
					mul_q24(m_p2, xy2));
				x = mul_q24(add_q24(x0, -dx), icd);
				y = mul_q24(add_q24(y0, -dy), icd);
			end
		end
		o.point_x = 32'(scale_depth(p.depth_mm, x));
		o.point_y = 32'(scale_depth(p.depth_mm, y));
		o.point_z = p.depth_mm;
		o.saturated = clip;
		return o;
	endfunction

	// ---------------- driver ----------------
	int send_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
			pix_data  <= '0;
			send_gap  <= 0;
		end else begin
			// retire the transfer that just happened at the rising edge
			if (pix_valid && pix_ready_s) begin
				if (send_gap == 0 && pixel_queue.size() > 1 && !hold_sender) begin
					void'(pixel_queue.pop_front());
					point_queue.push_back(project_pixel(pixel_queue[0]));
					pix_data <= pixel_queue[0];
					send_gap <= $urandom_range(0, 5);
				end else begin
					void'(pixel_queue.pop_front());
					pix_valid <= 1'b0;
					send_gap  <= $urandom_range(0, 5);
				end
			end else if (!pix_valid) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
				end else if (pixel_queue.size() > 0 && !hold_sender) begin
					// predict at launch: config is fixed while items fly
					point_queue.push_back(project_pixel(pixel_queue[0]));
					pix_data  <= pixel_queue[0];
					pix_valid <= 1'b1;
				end
			end
		end
	end

	// sample ready at the rising edge so the driver sees the transfer cleanly
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_ready_s <= 1'b0;
		end else begin
			pix_ready_s <= pix_ready;
		end
	end

	// ---------------- receiver and monitor ----------------
	int recv_gap;
	always @(negedge clk or negedge arst_n) begin
		int gap;
		if (!arst_n) begin
			pt_ready <= 1'b0;
			recv_gap <= 0;
		end else if (recv_gap > 0) begin
			pt_ready <= 1'b0;
			recv_gap <= recv_gap - 1;
		end else if (pt_ready && pt_seen) begin
			// draw a fresh stall after each transfer; zero keeps ready high
			gap = $urandom_range(0, 5);
			pt_ready <= (gap == 0);
			recv_gap <= (gap == 0) ? 0 : gap - 1;
		end else begin
			pt_ready <= 1'b1;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		dpbu_pkg::point_t want;
		if (!arst_n) begin
			pt_seen <= 1'b0;
			wdog    <= 0;
		end else begin
			pt_seen <= pt_valid && pt_ready;
			if ((pt_valid && pt_ready) || (pix_valid && pix_ready))
				wdog <= 0;
			else
				wdog <= wdog + 1;
			if (pt_valid && pt_ready) begin
				if (point_queue.size() == 0) begin
					report_mismatch("unexpected point", 64'(pt_data.point_z), 64'd0);
				end else begin
					want = point_queue.pop_front();
					if (pt_data.point_x !== want.point_x)
						report_mismatch("point_x", 64'(pt_data.point_x),
							64'(want.point_x));
					if (pt_data.point_y !== want.point_y)
						report_mismatch("point_y", 64'(pt_data.point_y),
							64'(want.point_y));
					if (pt_data.point_z !== want.point_z)
						report_mismatch("point_z", 64'(pt_data.point_z),
							64'(want.point_z));
					if (pt_data.saturated !== want.saturated)
						report_mismatch("saturated", 64'(pt_data.saturated),
							64'(want.saturated));
				end
			end
		end
	end

	// end the run when nothing transfers for too long
	always @(posedge clk) begin
		if (wdog >= WDOG_MAX) begin
			$display("depth_pixel_backproject_undistort_test failed");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	task automatic write_reg(input dpbu_pkg::cfg_idx_t idx, input logic [63:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dpbu_pkg::CFG_INV_FOCAL:       m_inv_focal = value;
			dpbu_pkg::CFG_PRINCIPAL_POINT: m_center = value;
			dpbu_pkg::CFG_RADIAL_K1:       m_k1 = $signed(value[31:0]);
			dpbu_pkg::CFG_RADIAL_K2:       m_k2 = $signed(value[31:0]);
			dpbu_pkg::CFG_RADIAL_K3:       m_k3 = $signed(value[31:0]);
			dpbu_pkg::CFG_TANGENTIAL_P1:   m_p1 = $signed(value[31:0]);
			dpbu_pkg::CFG_TANGENTIAL_P2:   m_p2 = $signed(value[31:0]);
			dpbu_pkg::CFG_UNDISTORT_EN:    m_undist = value[0];
			default: ;
		endcase
	endtask

	// wait until every queued pixel has left and every point has come back
	task automatic drain();
		while (pixel_queue.size() > 0 || pix_valid || point_queue.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic push_pixel(input logic [11:0] u, input logic [11:0] v,
			input logic [15:0] z);
		dpbu_pkg::pix_t p;
		p.pixel_col = u;
		p.pixel_row = v;
		p.depth_mm  = z;
		pixel_queue.push_back(p);
	endtask

	// camera: f about 300..1500 px, center column within 0..1400 px, center row word random
	task automatic set_camera(input bit undist, input int mag);
		logic [31:0] ifx, ify;
		ifx = 32'((64'd1 << 32) / $urandom_range(300, 1500));
		ify = 32'((64'd1 << 32) / $urandom_range(300, 1500));
		write_reg(dpbu_pkg::CFG_INV_FOCAL, {ify, ifx});
		write_reg(dpbu_pkg::CFG_PRINCIPAL_POINT,
			{32'($urandom_range(0, 1000)) << 16 | $urandom,
			32'($urandom_range(0, 1400)) << 16 | 32'($urandom_range(0, 65535))});
		write_reg(dpbu_pkg::CFG_RADIAL_K1, 64'($signed($urandom_range(0, 2 * mag)) - mag));
		write_reg(dpbu_pkg::CFG_RADIAL_K2, 64'($signed($urandom_range(0, 2 * mag)) - mag));
		write_reg(dpbu_pkg::CFG_RADIAL_K3, 64'($signed($urandom_range(0, 2 * mag)) - mag));
		write_reg(dpbu_pkg::CFG_TANGENTIAL_P1,
			64'($signed($urandom_range(0, mag / 8)) - mag / 16));
		write_reg(dpbu_pkg::CFG_TANGENTIAL_P2,
			64'($signed($urandom_range(0, mag / 8)) - mag / 16));
		write_reg(dpbu_pkg::CFG_UNDISTORT_EN, {63'd0, undist});
	endtask

	task automatic push_random(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				push_pixel($urandom_range(0, 1) ? 12'hFFF : 12'h000,
					$urandom_range(0, 1) ? 12'hFFF : 12'h000,
					$urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
			else
				push_pixel(12'($urandom_range(0, 1500)), 12'($urandom_range(0, 1100)),
					16'($urandom_range(0, 65535)));
		end
	endtask

	initial begin
		errors = 0;
		hold_sender = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		m_inv_focal = '0;
		m_center = '0;
		m_k1 = 0; m_k2 = 0; m_k3 = 0; m_p1 = 0; m_p2 = 0;
		m_undist = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset configuration: x and y land at zero
		push_pixel(12'hFFF, 12'hFFF, 16'hFFFF);
		push_pixel(12'h000, 12'h000, 16'h0000);
		drain();

		// register extremes: huge inverse focal and K1 = -1.0, so the denominator 1 - r2 can reach zero
		write_reg(dpbu_pkg::CFG_INV_FOCAL, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(dpbu_pkg::CFG_PRINCIPAL_POINT, 64'h0000_0000_FFFF_FFFF);
		write_reg(dpbu_pkg::CFG_RADIAL_K1, 64'hFFFF_FFFF_FF00_0000);
		write_reg(dpbu_pkg::CFG_RADIAL_K2, 64'h0);
		write_reg(dpbu_pkg::CFG_RADIAL_K3, 64'h0);
		write_reg(dpbu_pkg::CFG_TANGENTIAL_P1, 64'h0);
		write_reg(dpbu_pkg::CFG_TANGENTIAL_P2, 64'h0);
		write_reg(dpbu_pkg::CFG_UNDISTORT_EN, 64'h1);
		push_pixel(12'hFFF, 12'h000, 16'hFFFF);
		push_pixel(12'h000, 12'hFFF, 16'h0001);
		push_pixel(12'h800, 12'h800, 16'h8000);
		push_pixel(12'h001, 12'h001, 16'hFFFF);
		drain();

		write_reg(dpbu_pkg::CFG_RADIAL_K1, 64'h7FFF_FFFF);
		write_reg(dpbu_pkg::CFG_RADIAL_K2, 64'h8000_0000);
		write_reg(dpbu_pkg::CFG_RADIAL_K3, 64'h7FFF_FFFF);
		write_reg(dpbu_pkg::CFG_TANGENTIAL_P1, 64'h8000_0000);
		write_reg(dpbu_pkg::CFG_TANGENTIAL_P2, 64'h7FFF_FFFF);
		write_reg(dpbu_pkg::CFG_INV_FOCAL, 64'h0010_0000_0010_0000);
		write_reg(dpbu_pkg::CFG_PRINCIPAL_POINT, 64'h0200_0000_0280_0000);
		push_pixel(12'hFFF, 12'hFFF, 16'hFFFF);
		push_pixel(12'h000, 12'h000, 16'hFFFF);
		push_pixel(12'h280, 12'h200, 16'h1234);
		drain();

		// undistortion off with the same camera
		write_reg(dpbu_pkg::CFG_UNDISTORT_EN, 64'h0);
		push_pixel(12'hFFF, 12'h000, 16'hFFFF);
		push_pixel(12'h000, 12'hFFF, 16'hFFFF);
		drain();

		// random phases over several camera settings
		for (int ph = 0; ph < 8; ph++) begin
			set_camera(ph % 4 != 3, (ph < 4) ? 32'h0040_0000 : 32'h0400_0000);
			push_random(N_RANDOM / 8 / 2);
			// hold the sender until everything already sent has come back
			while (pixel_queue.size() > 0 || pix_valid) @(posedge clk);
			@(negedge clk);
			hold_sender = 1'b1;
			push_random(N_RANDOM / 8 / 2);
			while (point_queue.size() > 0) @(posedge clk);
			@(negedge clk);
			hold_sender = 1'b0;
			drain();
		end

		if (errors == 0 && point_queue.size() == 0)
			$display("depth_pixel_backproject_undistort_test passed");
		else
			$display("depth_pixel_backproject_undistort_test failed");
		$finish;
	end
endmodule
